// ===== rtl/eulrot_pkg.sv =====
// ----------------------------------------------------------------------------
// eulrot_pkg
// Shared widths, sine table and fixed-point helpers for the ZYX rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package eulrot_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int ANG_W       = 10;
   localparam int OUT_W       = 16;
   localparam int VAL_W       = FRAC_BITS + 2;
   localparam int TAB_W       = FRAC_BITS + 1;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int SUM_W       = VAL_W + 1;
   localparam int EXT_W       = (VAL_W > OUT_W) ? VAL_W : OUT_W;
   localparam int DEG_W       = 9;
   localparam int RED_W       = ANG_W + 2;
   localparam int DEG_FULL    = 360;
   localparam int DEG_3Q      = 270;
   localparam int DEG_HALF    = 180;
   localparam int DEG_QUARTER = 90;
   localparam int QIDX_W      = $clog2(DEG_QUARTER + 1);
   localparam int SIN_SH      = 30 - FRAC_BITS;

   localparam logic [63:0] PI30  = 64'd3373259426;
   localparam logic [63:0] ONE30 = 64'd1 << 30;

   localparam logic signed [VAL_W-1:0]  ONE      = {2'b01, {FRAC_BITS{1'b0}}};
   localparam logic signed [VAL_W-1:0]  NEG_ONE  = -ONE;
   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

   typedef logic [DEG_QUARTER:0][TAB_W-1:0] sin_tab_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] s;
      logic signed [VAL_W-1:0] c;
   } trig_type;

   // sin(0..90 deg): Taylor series at 30 fraction bits, rounded to FRAC_BITS
   function automatic sin_tab_type build_sin_tab();
      sin_tab_type      tab;
      logic [63:0]      x;
      logic [63:0]      x2;
      logic [63:0]      term;
      logic [63:0]      rnd;
      logic signed [63:0] sum;
      tab = '0;
      rnd = (64'd1 << SIN_SH) >> 1;
      for (int k = 0; k <= DEG_QUARTER; k++) begin
         if (k == 0) begin
            sum = 64'sd0;
         end else if (k == DEG_QUARTER) begin
            sum = $signed(ONE30);
         end else begin
            x    = (64'(k) * PI30 + 64'd90) / 64'd180;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 3; n <= 17; n += 2) begin
               term = ((term * x2) >> 30) / 64'((n - 1) * n);
               if (((n >> 1) & 1) == 1) sum = sum - $signed(term);
               else sum = sum + $signed(term);
            end
            if (sum < 0) sum = 64'sd0;
            if (sum > $signed(ONE30)) sum = $signed(ONE30);
         end
         sum    = $signed(($unsigned(sum) + rnd) >> SIN_SH);
         tab[k] = sum[TAB_W-1:0];
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

   // round(a*b / 2^FRAC_BITS), half up
   function automatic logic signed [VAL_W-1:0] fmul(input logic signed [VAL_W-1:0] a,
                                                    input logic signed [VAL_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b);
      p = (p + HALF_LSB) >>> FRAC_BITS;
      return p[VAL_W-1:0];
   endfunction

   function automatic logic signed [VAL_W-1:0] sat(input logic signed [SUM_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > SUM_W'(ONE)) r = ONE;
      else if (v < SUM_W'(NEG_ONE)) r = NEG_ONE;
      else r = v[VAL_W-1:0];
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input logic signed [VAL_W-1:0] v);
      logic signed [EXT_W-1:0] e;
      e = EXT_W'(v);
      return e[OUT_W-1:0];
   endfunction

endpackage

// ===== rtl/euler_angles_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// ZYX Euler rotation matrix Rz*Ry*Rx from whole-degree angles, Q1.14 out.
// ----------------------------------------------------------------------------
// Five-stage pipeline: angle reduction, sine/cosine table lookup, first
// products, triple products, then sums with saturation into the output
// register. One beat is accepted every cycle while the pipeline is not
// stalled. The whole pipeline holds while the output beat is stalled, so
// req_stall follows rsp_stall when a result is waiting.
module euler_angles_to_rotation_matrix (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [eulrot_pkg::ANG_W-1:0]   req_x_angle,
   input  logic signed [eulrot_pkg::ANG_W-1:0]   req_y_angle,
   input  logic signed [eulrot_pkg::ANG_W-1:0]   req_z_angle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m00,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m01,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m02,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m10,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m11,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m12,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m20,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m21,
   output logic signed [eulrot_pkg::OUT_W-1:0]   rsp_m22
);

   localparam int VW = eulrot_pkg::VAL_W;
   localparam int SW = eulrot_pkg::SUM_W;

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   eulrot_pkg::trig_type tx, ty, tz;

   // stage 3
   logic signed [VW-1:0] casb3_ff, sasb3_ff, m00p3_ff, m10p3_ff;
   logic signed [VW-1:0] sacg3_ff, sasg3_ff, cacg3_ff, casg3_ff;
   logic signed [VW-1:0] m21p3_ff, m22p3_ff, sg3_ff, cg3_ff, nsb3_ff;
   // stage 4
   logic signed [VW-1:0] t01_ff, t02_ff, t11_ff, t12_ff;
   logic signed [VW-1:0] sacg4_ff, sasg4_ff, cacg4_ff, casg4_ff;
   logic signed [VW-1:0] m00p4_ff, m10p4_ff, m21p4_ff, m22p4_ff, nsb4_ff;
   // stage 5
   logic signed [VW-1:0] m00_ff, m01_ff, m02_ff, m10_ff, m11_ff, m12_ff;
   logic signed [VW-1:0] m20_ff, m21_ff, m22_ff;
   logic signed [VW-1:0] m01_in, m02_in, m11_in, m12_in;

   assign advance   = !v5_ff || !rsp_stall;
   assign req_stall = !advance;

   eulrot_sincos u_sc_x (.clock(clock), .advance(advance), .angle(req_x_angle), .trig(tx));
   eulrot_sincos u_sc_y (.clock(clock), .advance(advance), .angle(req_y_angle), .trig(ty));
   eulrot_sincos u_sc_z (.clock(clock), .advance(advance), .angle(req_z_angle), .trig(tz));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // sa,ca = z; sb,cb = y; sg,cg = x
   always_ff @(posedge clock) begin
      if (advance) begin
         casb3_ff <= eulrot_pkg::fmul(tz.c, ty.s);
         sasb3_ff <= eulrot_pkg::fmul(tz.s, ty.s);
         m00p3_ff <= eulrot_pkg::fmul(tz.c, ty.c);
         m10p3_ff <= eulrot_pkg::fmul(tz.s, ty.c);
         sacg3_ff <= eulrot_pkg::fmul(tz.s, tx.c);
         sasg3_ff <= eulrot_pkg::fmul(tz.s, tx.s);
         cacg3_ff <= eulrot_pkg::fmul(tz.c, tx.c);
         casg3_ff <= eulrot_pkg::fmul(tz.c, tx.s);
         m21p3_ff <= eulrot_pkg::fmul(ty.c, tx.s);
         m22p3_ff <= eulrot_pkg::fmul(ty.c, tx.c);
         sg3_ff   <= tx.s;
         cg3_ff   <= tx.c;
         nsb3_ff  <= -ty.s;

         t01_ff   <= eulrot_pkg::fmul(casb3_ff, sg3_ff);
         t02_ff   <= eulrot_pkg::fmul(casb3_ff, cg3_ff);
         t11_ff   <= eulrot_pkg::fmul(sasb3_ff, sg3_ff);
         t12_ff   <= eulrot_pkg::fmul(sasb3_ff, cg3_ff);
         sacg4_ff <= sacg3_ff;
         sasg4_ff <= sasg3_ff;
         cacg4_ff <= cacg3_ff;
         casg4_ff <= casg3_ff;
         m00p4_ff <= m00p3_ff;
         m10p4_ff <= m10p3_ff;
         m21p4_ff <= m21p3_ff;
         m22p4_ff <= m22p3_ff;
         nsb4_ff  <= nsb3_ff;

         m00_ff   <= m00p4_ff;
         m01_ff   <= m01_in;
         m02_ff   <= m02_in;
         m10_ff   <= m10p4_ff;
         m11_ff   <= m11_in;
         m12_ff   <= m12_in;
         m20_ff   <= nsb4_ff;
         m21_ff   <= m21p4_ff;
         m22_ff   <= m22p4_ff;
      end
   end

   always_comb begin
      m01_in = eulrot_pkg::sat(SW'(t01_ff) - SW'(sacg4_ff));
      m02_in = eulrot_pkg::sat(SW'(t02_ff) + SW'(sasg4_ff));
      m11_in = eulrot_pkg::sat(SW'(t11_ff) + SW'(cacg4_ff));
      m12_in = eulrot_pkg::sat(SW'(t12_ff) - SW'(casg4_ff));
   end

   assign rsp_valid = v5_ff;
   assign rsp_m00   = eulrot_pkg::to_out(m00_ff);
   assign rsp_m01   = eulrot_pkg::to_out(m01_ff);
   assign rsp_m02   = eulrot_pkg::to_out(m02_ff);
   assign rsp_m10   = eulrot_pkg::to_out(m10_ff);
   assign rsp_m11   = eulrot_pkg::to_out(m11_ff);
   assign rsp_m12   = eulrot_pkg::to_out(m12_ff);
   assign rsp_m20   = eulrot_pkg::to_out(m20_ff);
   assign rsp_m21   = eulrot_pkg::to_out(m21_ff);
   assign rsp_m22   = eulrot_pkg::to_out(m22_ff);

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (m01_ff <= eulrot_pkg::ONE && m01_ff >= eulrot_pkg::NEG_ONE &&
                 m11_ff <= eulrot_pkg::ONE && m11_ff >= eulrot_pkg::NEG_ONE))
      else $error("rotation entry outside unit range");

   a_rsp_from_s4: assert property (@(posedge clock) disable iff (reset)
      $rose(v5_ff) |-> $past(v4_ff))
      else $error("result beat without a stage-4 item");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff}))
      else $error("pipeline moved while stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted beat lost at stage 1");

endmodule

// ===== rtl/eulrot_sincos.sv =====
// ----------------------------------------------------------------------------
// eulrot_sincos
// Two-stage angle unit: reduce modulo 360, then quarter-wave sine/cosine.
// ----------------------------------------------------------------------------
module eulrot_sincos (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic signed [eulrot_pkg::ANG_W-1:0]    angle,
   output eulrot_pkg::trig_type                   trig
);

   localparam int RW = eulrot_pkg::RED_W;
   localparam int DW = eulrot_pkg::DEG_W;
   localparam int VW = eulrot_pkg::VAL_W;

   logic signed [RW-1:0] t0;
   logic signed [RW-1:0] t1;
   logic signed [RW-1:0] tc;
   logic [DW-1:0]        sin_deg_ff, sin_deg_in;
   logic [DW-1:0]        cos_deg_ff, cos_deg_in;
   eulrot_pkg::trig_type trig_ff, trig_in;

   function automatic logic signed [VW-1:0] sin_lookup(input logic [DW-1:0] d);
      logic [DW-1:0]          idx;
      logic                   neg;
      logic signed [VW-1:0]   mag;
      if (d <= DW'(eulrot_pkg::DEG_QUARTER)) begin
         idx = d;
         neg = 1'b0;
      end else if (d <= DW'(eulrot_pkg::DEG_HALF)) begin
         idx = DW'(eulrot_pkg::DEG_HALF) - d;
         neg = 1'b0;
      end else if (d <= DW'(eulrot_pkg::DEG_3Q)) begin
         idx = d - DW'(eulrot_pkg::DEG_HALF);
         neg = 1'b1;
      end else begin
         idx = DW'(eulrot_pkg::DEG_FULL) - d;
         neg = 1'b1;
      end
      mag = {1'b0, eulrot_pkg::SIN_TAB[idx[eulrot_pkg::QIDX_W-1:0]]};
      return neg ? -mag : mag;
   endfunction

   always_comb begin
      t0 = (angle < 0) ? RW'(angle) + RW'(eulrot_pkg::DEG_FULL) : RW'(angle);
      if (t0 < 0) t1 = t0 + RW'(eulrot_pkg::DEG_FULL);
      else if (t0 >= RW'(eulrot_pkg::DEG_FULL)) t1 = t0 - RW'(eulrot_pkg::DEG_FULL);
      else t1 = t0;
      tc = t1 + RW'(eulrot_pkg::DEG_QUARTER);
      if (tc >= RW'(eulrot_pkg::DEG_FULL)) tc = tc - RW'(eulrot_pkg::DEG_FULL);
      sin_deg_in = t1[DW-1:0];
      cos_deg_in = tc[DW-1:0];
      trig_in.s  = sin_lookup(sin_deg_ff);
      trig_in.c  = sin_lookup(cos_deg_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_deg_ff <= sin_deg_in;
         cos_deg_ff <= cos_deg_in;
         trig_ff    <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

// ===== tb/tb_euler_angles_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// tb_euler_angles_to_rotation_matrix
// Drives angle triples into the ZYX rotation matrix pipeline and checks all
// nine Q1.14 entries of every result beat against an in-bench fixed-point
// predictor. Directed corner triples first, then random triples, with random
// idle/stall cycles on both channels and one full drain between the phases.
// ----------------------------------------------------------------------------
module tb_euler_angles_to_rotation_matrix;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [eulrot_pkg::ANG_W-1:0] x;
      logic signed [eulrot_pkg::ANG_W-1:0] y;
      logic signed [eulrot_pkg::ANG_W-1:0] z;
   } angles_type;

   typedef logic [8:0][eulrot_pkg::OUT_W-1:0] matrix_type;

   localparam longint unsigned PI_Q30   = 64'd3373259426;
   localparam longint          UNITY_Q30 = 64'sd1 << 30;
   localparam int              N_RANDOM = 850;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [eulrot_pkg::ANG_W-1:0]  req_x_angle = '0;
   logic signed [eulrot_pkg::ANG_W-1:0]  req_y_angle = '0;
   logic signed [eulrot_pkg::ANG_W-1:0]  req_z_angle = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [eulrot_pkg::OUT_W-1:0]  rsp_m00, rsp_m01, rsp_m02;
   logic signed [eulrot_pkg::OUT_W-1:0]  rsp_m10, rsp_m11, rsp_m12;
   logic signed [eulrot_pkg::OUT_W-1:0]  rsp_m20, rsp_m21, rsp_m22;

   angles_type  angle_q[$];
   matrix_type  pending_mats[$];
   angles_type  in_flight;
   longint      quarter_sine [0:90];
   int          n_queued = 0;
   int          n_accepted = 0;
   int          err_count = 0;
   bit          steady = 1'b0;

   euler_angles_to_rotation_matrix dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_x_angle (req_x_angle),
      .req_y_angle (req_y_angle),
      .req_z_angle (req_z_angle),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_m00     (rsp_m00),
      .rsp_m01     (rsp_m01),
      .rsp_m02     (rsp_m02),
      .rsp_m10     (rsp_m10),
      .rsp_m11     (rsp_m11),
      .rsp_m12     (rsp_m12),
      .rsp_m20     (rsp_m20),
      .rsp_m21     (rsp_m21),
      .rsp_m22     (rsp_m22)
   );

   always #2 clock = ~clock;

   // sin(0..90 deg) at 30 fraction bits via Taylor series, rounded to FRAC_BITS
   initial begin
      longint unsigned x, x2, term;
      longint          s;
      int              sh;
      sh = 30 - eulrot_pkg::FRAC_BITS;
      for (int k = 0; k <= 90; k++) begin
         if (k == 0) begin
            s = 0;
         end else if (k == 90) begin
            s = UNITY_Q30;
         end else begin
            x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            s    = longint'(x);
            for (int n = 3; n <= 17; n += 2) begin
               term = ((term * x2) >> 30) / longint'((n - 1) * n);
               if (((n >> 1) & 1) == 1) s = s - longint'(term);
               else s = s + longint'(term);
            end
            if (s < 0) s = 0;
            if (s > UNITY_Q30) s = UNITY_Q30;
         end
         if (sh > 0) s = (s + (longint'(1) << (sh - 1))) >>> sh;
         quarter_sine[k] = s;
      end
   end

   function automatic int wrap_degrees(logic signed [eulrot_pkg::ANG_W-1:0] a);
      int r;
      r = int'(a) % 360;
      if (r < 0) r += 360;
      return r;
   endfunction

   function automatic longint sine_of(int r);
      if (r <= 90) return quarter_sine[r];
      if (r <= 180) return quarter_sine[180 - r];
      if (r <= 270) return -quarter_sine[r - 180];
      return -quarter_sine[360 - r];
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (longint'(1) << (eulrot_pkg::FRAC_BITS - 1))) >>> eulrot_pkg::FRAC_BITS;
   endfunction

   function automatic matrix_type zyx_matrix(angles_type ang);
      int         rx, ry, rz;
      longint     sg, cg, sb, cb, sa, ca, casb, sasb, unity;
      longint     e [9];
      matrix_type m;
      rx = wrap_degrees(ang.x);
      ry = wrap_degrees(ang.y);
      rz = wrap_degrees(ang.z);
      sg = sine_of(rx);
      cg = sine_of((rx + 90) % 360);
      sb = sine_of(ry);
      cb = sine_of((ry + 90) % 360);
      sa = sine_of(rz);
      ca = sine_of((rz + 90) % 360);
      casb = qmul(ca, sb);
      sasb = qmul(sa, sb);
      e[0] = qmul(ca, cb);
      e[1] = qmul(casb, sg) - qmul(sa, cg);
      e[2] = qmul(casb, cg) + qmul(sa, sg);
      e[3] = qmul(sa, cb);
      e[4] = qmul(sasb, sg) + qmul(ca, cg);
      e[5] = qmul(sasb, cg) - qmul(ca, sg);
      e[6] = -sb;
      e[7] = qmul(cb, sg);
      e[8] = qmul(cb, cg);
      unity = longint'(1) << eulrot_pkg::FRAC_BITS;
      for (int i = 0; i < 9; i++) begin
         if (e[i] > unity) e[i] = unity;
         if (e[i] < -unity) e[i] = -unity;
         m[i] = e[i][eulrot_pkg::OUT_W-1:0];
      end
      return m;
   endfunction

   function automatic logic signed [eulrot_pkg::ANG_W-1:0] random_angle();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return eulrot_pkg::ANG_W'($urandom_range(1023));
      if (pick == 1) return eulrot_pkg::ANG_W'(int'($urandom_range(8)) * 90 - 360);
      return eulrot_pkg::ANG_W'(int'($urandom_range(720)) - 360);
   endfunction

   task automatic queue_triple(int x, int y, int z);
      angles_type a;
      a.x = eulrot_pkg::ANG_W'(x);
      a.y = eulrot_pkg::ANG_W'(y);
      a.z = eulrot_pkg::ANG_W'(z);
      angle_q.push_back(a);
      n_queued++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_mats.push_back(zyx_matrix(in_flight));
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (angle_q.size() > 0 && (steady || $urandom_range(99) >= 9)) begin
               in_flight = angle_q.pop_front();
               req_valid   <= 1'b1;
               req_x_angle <= in_flight.x;
               req_y_angle <= in_flight.y;
               req_z_angle <= in_flight.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      matrix_type want, got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_m22, rsp_m21, rsp_m20, rsp_m12, rsp_m11, rsp_m10,
                   rsp_m02, rsp_m01, rsp_m00};
            if (pending_mats.size() == 0) begin
               err_count++;
               if (err_count <= 10) $display("ERROR: result beat with none expected");
            end else begin
               want = pending_mats.pop_front();
               for (int i = 0; i < 9; i++) begin
                  if (got[i] !== want[i]) begin
                     err_count++;
                     if (err_count <= 10)
                        $display("ERROR: m%0d%0d expected %0d got %0d", i / 3, i % 3,
                                 $signed(want[i]), $signed(got[i]));
                  end
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 9);
      end
   end

   initial begin
      int corners [23][3];
      int guard;
      corners = '{
         '{0, 0, 0}, '{90, 0, 0}, '{0, 90, 0}, '{0, 0, 90},
         '{180, 180, 180}, '{270, 270, 270}, '{-90, -90, -90},
         '{360, -360, 360}, '{-360, 360, -360}, '{511, 511, 511},
         '{-512, -512, -512}, '{45, 45, 45}, '{30, 60, -45},
         '{1, -1, 89}, '{91, 179, 181}, '{269, 271, 359},
         '{-1, -359, -181}, '{90, 90, 90}, '{-90, 90, -90},
         '{45, 90, 45}, '{135, -45, 225}, '{-512, 511, 0}, '{400, -400, 500}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (corners[i]) queue_triple(corners[i][0], corners[i][1], corners[i][2]);

      // hold off until the pipeline has fully drained
      while (n_accepted < n_queued || pending_mats.size() > 0) @(posedge clock);

      steady = 1'b1;
      for (int i = 0; i < N_RANDOM; i++)
         queue_triple(random_angle(), random_angle(), random_angle());
      while (n_accepted < n_queued - 650) @(posedge clock);
      steady = 1'b0;

      while (n_accepted < n_queued) @(posedge clock);
      guard = 0;
      while (pending_mats.size() > 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      err_count += pending_mats.size();

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
